### src/sct_pkg.sv
// Shared types and constants for the sample-to-chunk lookup block.
`timescale 1ns / 1ps
package sct_pkg;

    localparam int unsigned DW      = 32;
    localparam int unsigned CFG_W   = 9;
    localparam int unsigned IDX_W   = 8;
    localparam int unsigned DCNT_W  = 5;
    localparam logic [DW-1:0] ALL_ONES = '1;
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;
    localparam logic ST_FOUND = 1'b0;
    localparam logic ST_ERROR = 1'b1;

    typedef struct packed {
        logic load;       // write one table entry
        logic start_q;    // capture sample, read entry 0
        logic take_cur;   // latch read data as current entry
        logic rd_next;    // read entry idx+1
        logic take_nxt;   // latch read data as next entry, form chunk delta
        logic mul;        // run length = delta * per
        logic advance;    // step to next entry
        logic div_init;
        logic div_step;
        logic out_ok;
        logic out_err;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic last;
        logic cur_zero;
        logic nxt_zero;
        logic lt;
        logic div_last;
    } t_sts;

endpackage

### src/sample_to_chunk_lookup.sv
// Top level of the sample-to-chunk lookup: controller plus datapath.
// Load request: written at the accepting edge, no result, busy stays low.
// Query request: result strobed on o_done once the run walk and the divide are done; each
// run compared costs a table read and a multiply, and the shift-subtract divider runs
// on the matching run. Errors return sooner. One query at a time.
// Synchronous active-low reset clears the state machine, r_entries and the done strobe.
`timescale 1ns / 1ps
module sample_to_chunk_lookup
    import sct_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             i_op,
    input  logic [IDX_W-1:0] i_entry_index,
    input  logic [DW-1:0]    i_first_chunk_in,
    input  logic [DW-1:0]    i_per_chunk_in,
    input  logic [DW-1:0]    i_desc_id_in,
    input  logic [DW-1:0]    i_sample_number,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data,
    output logic             o_done,
    output logic             o_status,
    output logic [DW-1:0]    o_chunk_number,
    output logic [DW-1:0]    o_offset_in_chunk,
    output logic [DW-1:0]    o_desc_id_out
);

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    sct_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_op    (i_op),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    sct_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_cfg_we          (i_cfg_valid & o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .i_entry_index     (i_entry_index),
        .i_first_chunk_in  (i_first_chunk_in),
        .i_per_chunk_in    (i_per_chunk_in),
        .i_desc_id_in      (i_desc_id_in),
        .i_sample_number   (i_sample_number),
        .o_done            (o_done),
        .o_status          (o_status),
        .o_chunk_number    (o_chunk_number),
        .o_offset_in_chunk (o_offset_in_chunk),
        .o_desc_id_out     (o_desc_id_out)
    );

endmodule

### src/sct_ctrl.sv
// Controller state machine for the sample-to-chunk lookup.
`timescale 1ns / 1ps
module sct_ctrl
    import sct_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic i_op,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RDCUR = 4'd1;
    localparam logic [3:0] S_EVAL  = 4'd2;
    localparam logic [3:0] S_NXT   = 4'd3;
    localparam logic [3:0] S_MUL   = 4'd4;
    localparam logic [3:0] S_CMP   = 4'd5;
    localparam logic [3:0] S_DIVS  = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;
    localparam logic [3:0] S_ERR   = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_op == OP_QUERY) begin
                        o_cmd.start_q = 1'b1;
                        n_state = S_RDCUR;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            S_RDCUR: begin
                o_cmd.take_cur = 1'b1;
                n_state = i_sts.empty ? S_ERR : S_EVAL;
            end
            S_EVAL: begin
                if (i_sts.cur_zero) begin
                    n_state = S_ERR;
                end else if (i_sts.last) begin
                    n_state = S_DIVS;
                end else begin
                    o_cmd.rd_next = 1'b1;
                    n_state = S_NXT;
                end
            end
            S_NXT: begin
                if (i_sts.nxt_zero) begin
                    n_state = S_ERR;
                end else begin
                    o_cmd.take_nxt = 1'b1;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_CMP;
            end
            S_CMP: begin
                if (i_sts.lt) begin
                    o_cmd.advance = 1'b1;
                    n_state = S_EVAL;
                end else begin
                    n_state = S_DIVS;
                end
            end
            S_DIVS: begin
                o_cmd.div_init = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = S_OUT;
            end
            S_OUT: begin
                o_cmd.out_ok = 1'b1;
                n_state = S_IDLE;
            end
            S_ERR: begin
                o_cmd.out_err = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

### src/sct_dp.sv
// Datapath: run table memories, run walk arithmetic and shift-subtract divider.
`timescale 1ns / 1ps
module sct_dp
    import sct_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic [IDX_W-1:0] i_entry_index,
    input  logic [DW-1:0]    i_first_chunk_in,
    input  logic [DW-1:0]    i_per_chunk_in,
    input  logic [DW-1:0]    i_desc_id_in,
    input  logic [DW-1:0]    i_sample_number,
    output logic             o_done,
    output logic             o_status,
    output logic [DW-1:0]    o_chunk_number,
    output logic [DW-1:0]    o_offset_in_chunk,
    output logic [DW-1:0]    o_desc_id_out
);

    localparam int unsigned AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW0 = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned CW  = (CW0 > CFG_W) ? CW0 : CFG_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    logic [DW-1:0] mem_fc  [TABLE_DEPTH];
    logic [DW-1:0] mem_per [TABLE_DEPTH];
    logic [DW-1:0] mem_id  [TABLE_DEPTH];

    logic [CFG_W-1:0] r_entries;
    logic [DW-1:0] r_rd_fc, r_rd_per, r_rd_id;
    logic [DW-1:0] r_cur_fc, r_cur_per, r_cur_id;
    logic [DW-1:0] r_nxt_fc, r_nxt_per, r_nxt_id;
    logic [DW-1:0] r_diff, r_prod, r_sample;
    logic [DW-1:0] r_rem, r_quo;
    logic [DCNT_W-1:0] r_dcnt;
    logic [CW-1:0] r_idx;
    logic r_done, r_status;
    logic [DW-1:0] r_chunk, r_off, r_id_out;

    logic [CW-1:0] n_cnt, idx_p1, cfg_ext;
    logic [AW-1:0] rd_addr, wr_addr;
    logic          wr_ok;
    logic [DW:0]   trial;
    logic          ge;

    assign cfg_ext = CW'(r_entries);
    assign n_cnt   = (cfg_ext > DEPTH_C) ? DEPTH_C : cfg_ext;
    assign idx_p1  = r_idx + 1'b1;
    assign rd_addr = i_cmd.rd_next ? idx_p1[AW-1:0] : '0;
    assign wr_addr = AW'(i_entry_index);
    assign wr_ok   = (DW'(i_entry_index) < DW'(TABLE_DEPTH));
    assign trial   = {r_rem, r_quo[DW-1]};
    assign ge      = (trial >= {1'b0, r_cur_per});

    assign o_sts.empty    = (n_cnt == '0);
    assign o_sts.last     = (idx_p1 >= n_cnt);
    assign o_sts.cur_zero = (r_cur_per == '0);
    assign o_sts.nxt_zero = (r_rd_per == '0);
    assign o_sts.lt       = (r_prod < r_sample);
    assign o_sts.div_last = (r_dcnt == '1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && wr_ok) begin
            mem_fc[wr_addr]  <= i_first_chunk_in;
            mem_per[wr_addr] <= i_per_chunk_in;
            mem_id[wr_addr]  <= i_desc_id_in;
        end
        r_rd_fc  <= mem_fc[rd_addr];
        r_rd_per <= mem_per[rd_addr];
        r_rd_id  <= mem_id[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries <= '0;
            r_done    <= 1'b0;
        end else begin
            if (i_cfg_we) r_entries <= i_cfg_data;
            r_done <= i_cmd.out_ok | i_cmd.out_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_q) begin
            r_sample <= i_sample_number;
            r_idx    <= '0;
        end
        if (i_cmd.take_cur) begin
            r_cur_fc  <= r_rd_fc;
            r_cur_per <= r_rd_per;
            r_cur_id  <= r_rd_id;
        end
        if (i_cmd.take_nxt) begin
            r_nxt_fc  <= r_rd_fc;
            r_nxt_per <= r_rd_per;
            r_nxt_id  <= r_rd_id;
            r_diff    <= r_rd_fc - r_cur_fc;
        end
        if (i_cmd.mul) r_prod <= r_diff * r_cur_per;
        if (i_cmd.advance) begin
            r_sample  <= r_sample - r_prod;
            r_idx     <= idx_p1;
            r_cur_fc  <= r_nxt_fc;
            r_cur_per <= r_nxt_per;
            r_cur_id  <= r_nxt_id;
        end
        if (i_cmd.div_init) begin
            r_rem  <= '0;
            r_quo  <= r_sample;
            r_dcnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem  <= ge ? DW'(trial - {1'b0, r_cur_per}) : trial[DW-1:0];
            r_quo  <= {r_quo[DW-2:0], ge};
            r_dcnt <= r_dcnt + 1'b1;
        end
        if (i_cmd.out_ok) begin
            r_status <= ST_FOUND;
            r_id_out <= r_cur_id;
            if (r_rem != '0) begin
                r_chunk <= r_cur_fc + r_quo;
                r_off   <= r_rem;
            end else begin
                r_chunk <= r_cur_fc + r_quo - 1'b1;
                r_off   <= r_cur_per;
            end
        end
        if (i_cmd.out_err) begin
            r_status <= ST_ERROR;
            r_chunk  <= ALL_ONES;
            r_off    <= ALL_ONES;
            r_id_out <= ALL_ONES;
        end
    end

    assign o_done            = r_done;
    assign o_status          = r_status;
    assign o_chunk_number    = r_chunk;
    assign o_offset_in_chunk = r_off;
    assign o_desc_id_out     = r_id_out;

endmodule

### tb/tb_sample_to_chunk_lookup.sv
// Self-checking testbench for the sample-to-chunk lookup block.
`timescale 1ns / 1ps
module tb_sample_to_chunk_lookup;
    import sct_pkg::*;

    localparam int unsigned DEPTH = 256;
    localparam int unsigned CYCLE_LIMIT = 4000000;
    localparam int unsigned SETTLE_CYCLES = 10;

    typedef enum logic [1:0] {REQ_LOAD, REQ_QUERY, REQ_CFG} t_req_kind;
    typedef enum logic [2:0] {DS_FETCH, DS_GAP, DS_REQ, DS_DRAIN, DS_CFG} t_drv_state;

    typedef struct {
        t_req_kind        kind;
        logic [IDX_W-1:0] idx;
        logic [DW-1:0]    start_chunk;
        logic [DW-1:0]    per_chunk;
        logic [DW-1:0]    desc_id;
        logic [DW-1:0]    sample;
        logic [CFG_W-1:0] cfg;
        int unsigned      gap;
    } t_request;

    typedef struct packed {
        logic          status;
        logic [DW-1:0] chunk;
        logic [DW-1:0] offset;
        logic [DW-1:0] desc_id;
    } t_location;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic             i_op;
    logic [IDX_W-1:0] i_entry_index;
    logic [DW-1:0]    i_first_chunk_in;
    logic [DW-1:0]    i_per_chunk_in;
    logic [DW-1:0]    i_desc_id_in;
    logic [DW-1:0]    i_sample_number;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_data;
    logic             o_done;
    logic             o_status;
    logic [DW-1:0]    o_chunk_number;
    logic [DW-1:0]    o_offset_in_chunk;
    logic [DW-1:0]    o_desc_id_out;

    sample_to_chunk_lookup u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_op              (i_op),
        .i_entry_index     (i_entry_index),
        .i_first_chunk_in  (i_first_chunk_in),
        .i_per_chunk_in    (i_per_chunk_in),
        .i_desc_id_in      (i_desc_id_in),
        .i_sample_number   (i_sample_number),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .o_done            (o_done),
        .o_status          (o_status),
        .o_chunk_number    (o_chunk_number),
        .o_offset_in_chunk (o_offset_in_chunk),
        .o_desc_id_out     (o_desc_id_out)
    );

    // table shadow
    logic [DW-1:0]    run_fc   [DEPTH];
    logic [DW-1:0]    run_per  [DEPTH];
    logic [DW-1:0]    run_desc [DEPTH];
    logic [CFG_W-1:0] runs_in_use;

    t_request    pending_reqs[$];
    t_location   expected_locs[$];
    int unsigned error_count = 0;
    bit          fill_done;
    bit          all_sent;
    longint unsigned cycle_count = 0;

    bit            no_idle;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_location locate_sample(input logic [DW-1:0] sample_in);
        t_location     loc;
        logic [DW-1:0] sample;
        logic [DW-1:0] count;
        int unsigned   n;
        sample = sample_in;
        n = (runs_in_use > DEPTH) ? DEPTH : runs_in_use;
        loc = '{ST_ERROR, ALL_ONES, ALL_ONES, ALL_ONES};
        for (int unsigned i = 0; i < n; i++) begin
            if (run_per[i] == '0) break;
            if (i + 1 < n) begin
                if (run_per[i+1] == '0) break;
                count = (run_fc[i+1] - run_fc[i]) * run_per[i];
                if (count < sample) begin
                    sample = sample - count;
                    continue;
                end
            end
            loc.status  = ST_FOUND;
            loc.desc_id = run_desc[i];
            if (sample % run_per[i] != '0) begin
                loc.chunk  = run_fc[i] + sample / run_per[i];
                loc.offset = sample % run_per[i];
            end else begin
                loc.chunk  = run_fc[i] + sample / run_per[i] - 1;
                loc.offset = run_per[i];
            end
            return loc;
        end
        return loc;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle) return 0;
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(15, 60);
    endfunction

    task automatic add_load(input logic [IDX_W-1:0] idx, input logic [DW-1:0] fc,
                            input logic [DW-1:0] per, input logic [DW-1:0] desc);
        t_request r;
        r = '{REQ_LOAD, idx, fc, per, desc, $urandom, '0, pick_gap()};
        pending_reqs.push_back(r);
    endtask

    task automatic add_query(input logic [DW-1:0] sample);
        t_request r;
        r = '{REQ_QUERY, IDX_W'($urandom), $urandom, $urandom, $urandom, sample, '0,
              pick_gap()};
        pending_reqs.push_back(r);
    endtask

    task automatic add_cfg(input logic [CFG_W-1:0] value);
        t_request r;
        r = '{REQ_CFG, '0, '0, '0, '0, '0, value, 0};
        pending_reqs.push_back(r);
    endtask

    // rewrite the head of the table as consecutive runs, with some broken entries
    task automatic rewrite_runs(input int unsigned cnt);
        logic [DW-1:0] fc;
        logic [DW-1:0] per;
        int unsigned   r;
        fc = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 4);
        for (int unsigned i = 0; i < cnt; i++) begin
            r = $urandom_range(0, 99);
            per = $urandom_range(1, 20);
            if (r < 8) per = '0;
            else if (r < 12) per = $urandom;
            add_load(IDX_W'(i), (r >= 12 && r < 16) ? $urandom : fc, per, $urandom);
            fc = fc + $urandom_range(1, 5);
        end
    endtask

    function automatic logic [DW-1:0] pick_sample();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 1200);
        if (r < 85) return $urandom;
        return $urandom_range(0, 3);
    endfunction

    initial begin
        logic [DW-1:0] fc;
        int unsigned   n_items;
        int unsigned   n_rw;
        logic [CFG_W-1:0] phases [12];
        phases = '{9'd1, 9'd2, 9'd3, 9'd256, 9'd5, 9'd8, 9'd511, 9'd4, 9'd16, 9'd0, 9'd6, 9'd64};
        no_idle = 1'b0;

        // empty table
        add_query('0);
        add_query(32'd1);
        add_query(ALL_ONES);
        // fill the whole table as one long list of runs
        fc = 32'd1;
        for (int unsigned i = 0; i < DEPTH; i++) begin
            add_load(IDX_W'(i), fc, $urandom_range(1, 12), $urandom);
            fc = fc + $urandom_range(1, 3);
        end
        add_cfg(9'd1);
        add_load(8'd0, ALL_ONES, ALL_ONES, ALL_ONES);
        add_query(ALL_ONES);
        add_query('0);
        add_query(32'd1);
        add_load(8'd0, 32'd1, 32'd1, '0);
        add_query(ALL_ONES);
        add_query(32'd7);
        add_cfg(9'd2);
        add_load(8'd1, 32'd1, '0, ALL_ONES);
        add_query(32'd1);
        add_load(8'd1, 32'd3, 32'd4, ALL_ONES);
        add_query(32'd2);
        add_query(32'd3);
        add_query(ALL_ONES);
        add_load(8'd0, '0, '0, '0);
        add_query(32'd1);

        foreach (phases[p]) begin
            no_idle = (p % 4 == 3);
            add_cfg(phases[p]);
            n_rw = (phases[p] > 8) ? 8 : phases[p];
            rewrite_runs(n_rw);
            n_items = (phases[p] >= 64) ? 14 : 70;
            for (int unsigned k = 0; k < n_items; k++) begin
                if ($urandom_range(0, 99) < 20) begin
                    if (n_rw != 0 && $urandom_range(0, 1) == 1)
                        rewrite_runs(n_rw);
                    else
                        add_load(IDX_W'($urandom), $urandom, $urandom_range(0, 30),
                                 $urandom);
                end else begin
                    add_query(pick_sample());
                end
            end
        end
        fill_done = 1'b1;
    end

    // driver
    t_drv_state  drv_state;
    t_request    cur_req;
    int unsigned gap_left;
    int unsigned settle;

    always @(posedge i_clk) begin
        logic go;
        bit   fetch;
        go = start;
        fetch = 1'b0;
        if (!i_rst_n) begin
            go               = 1'b0;
            runs_in_use      = '0;
            i_op             <= OP_LOAD;
            i_entry_index    <= '0;
            i_first_chunk_in <= '0;
            i_per_chunk_in   <= '0;
            i_desc_id_in     <= '0;
            i_sample_number  <= '0;
            i_cfg_data       <= '0;
            i_cfg_valid      <= 1'b0;
            drv_state        <= DS_FETCH;
            all_sent         <= 1'b0;
        end else begin
            case (drv_state)
                DS_FETCH: fetch = 1'b1;
                DS_GAP: begin
                    if (gap_left <= 1) begin
                        go = 1'b1;
                        drv_state <= DS_REQ;
                    end
                    gap_left <= gap_left - 1;
                end
                DS_REQ: begin
                    if (start && !busy) begin
                        go = 1'b0;
                        if (cur_req.kind == REQ_LOAD) begin
                            run_fc[cur_req.idx]   = cur_req.start_chunk;
                            run_per[cur_req.idx]  = cur_req.per_chunk;
                            run_desc[cur_req.idx] = cur_req.desc_id;
                        end else begin
                            expected_locs.push_back(locate_sample(cur_req.sample));
                        end
                        fetch = 1'b1;
                    end
                end
                DS_DRAIN: begin
                    if (expected_locs.size() == 0 && !busy) begin
                        if (settle + 1 >= SETTLE_CYCLES) begin
                            i_cfg_valid <= 1'b1;
                            i_cfg_data  <= cur_req.cfg;
                            drv_state   <= DS_CFG;
                        end
                        settle <= settle + 1;
                    end else begin
                        settle <= 0;
                    end
                end
                DS_CFG: begin
                    if (i_cfg_valid && o_cfg_ready) begin
                        runs_in_use = cur_req.cfg;
                        i_cfg_valid <= 1'b0;
                        drv_state   <= DS_FETCH;
                    end
                end
                default: drv_state <= DS_FETCH;
            endcase
            if (fetch) begin
                if (pending_reqs.size() != 0) begin
                    cur_req = pending_reqs.pop_front();
                    i_op             <= (cur_req.kind == REQ_QUERY) ? OP_QUERY : OP_LOAD;
                    i_entry_index    <= cur_req.idx;
                    i_first_chunk_in <= cur_req.start_chunk;
                    i_per_chunk_in   <= cur_req.per_chunk;
                    i_desc_id_in     <= cur_req.desc_id;
                    i_sample_number  <= cur_req.sample;
                    if (cur_req.kind == REQ_CFG) begin
                        settle    <= 0;
                        drv_state <= DS_DRAIN;
                    end else if (cur_req.gap != 0) begin
                        gap_left  <= cur_req.gap;
                        drv_state <= DS_GAP;
                    end else begin
                        go = 1'b1;
                        drv_state <= DS_REQ;
                    end
                end else begin
                    drv_state <= DS_FETCH;
                    if (fill_done) all_sent <= 1'b1;
                end
            end
        end
        start <= go;
    end

    // monitor
    always @(posedge i_clk) begin
        t_location want;
        if (i_rst_n && o_done) begin
            if (expected_locs.size() == 0) begin
                $display("%0t: unexpected result status=%0b chunk=%h offset=%h desc=%h",
                         $time, o_status, o_chunk_number, o_offset_in_chunk, o_desc_id_out);
                error_count++;
            end else begin
                want = expected_locs.pop_front();
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0b actual %0b", $time, want.status,
                             o_status);
                    error_count++;
                end
                if (o_chunk_number !== want.chunk) begin
                    $display("%0t: chunk_number expected %h actual %h", $time, want.chunk,
                             o_chunk_number);
                    error_count++;
                end
                if (o_offset_in_chunk !== want.offset) begin
                    $display("%0t: offset_in_chunk expected %h actual %h", $time,
                             want.offset, o_offset_in_chunk);
                    error_count++;
                end
                if (o_desc_id_out !== want.desc_id) begin
                    $display("%0t: desc_id_out expected %h actual %h", $time, want.desc_id,
                             o_desc_id_out);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (!(all_sent && expected_locs.size() == 0)) @(posedge i_clk);
        repeat (1200) @(posedge i_clk);
        if (error_count == 0 && expected_locs.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### filelist.f
src/sct_pkg.sv
src/sct_ctrl.sv
src/sct_dp.sv
src/sample_to_chunk_lookup.sv
tb/tb_sample_to_chunk_lookup.sv
